FILE: rtl/core/integer_to_ascii_formatter_macros.svh
// Assertion macros for the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS
`define I2A_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define I2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define I2A_ASSERT(label, clk, rst_n, expr)
`define I2A_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/i2a_pkg.sv
// Constants, control word layout and microcode table of the formatter.
`default_nettype none

package i2a_pkg;

    localparam int unsigned S_DATA_W = 104;
    localparam int unsigned M_DATA_W = 40;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned COUNT_W  = 31;
    localparam int unsigned BCD_W    = 40;
    localparam int unsigned CNT_W    = 6;
    localparam int unsigned STEP_W   = 4;
    localparam int unsigned ACT_W    = 3;
    localparam int unsigned COND_W   = 3;

    localparam logic [1:0] OP_HEX_LOWER = 2'd0;
    localparam logic [1:0] OP_HEX_UPPER = 2'd1;
    localparam logic [1:0] OP_DEC       = 2'd2;
    localparam logic [1:0] OP_PTR       = 2'd3;

    localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD       = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SKIP       = 3'd2;
    localparam logic [ACT_W-1:0] ACT_EMIT_DIGIT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_EMIT_CONST = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DABBLE     = 3'd5;

    localparam logic [COND_W-1:0] COND_ALWAYS      = 3'd0;
    localparam logic [COND_W-1:0] COND_ACCEPT      = 3'd1;
    localparam logic [COND_W-1:0] COND_VAL_ZERO    = 3'd2;
    localparam logic [COND_W-1:0] COND_SKIP_DONE   = 3'd3;
    localparam logic [COND_W-1:0] COND_LAST_DIGIT  = 3'd4;
    localparam logic [COND_W-1:0] COND_DABBLE_DONE = 3'd5;

    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_PTR    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_PFX0   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_PFXX   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SKIP   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DIGIT  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DABBLE = 4'd6;
    localparam logic [STEP_W-1:0] STEP_NIL0   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_NIL1   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_NIL2   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_NIL3   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_NIL4   = 4'd11;

    localparam logic [CNT_W-1:0] DIGITS_HEX64 = 6'd16;
    localparam logic [CNT_W-1:0] DIGITS_HEX32 = 6'd8;
    localparam logic [CNT_W-1:0] DIGITS_DEC   = 6'd10;
    localparam logic [CNT_W-1:0] DABBLE_BITS  = 6'd32;

    localparam logic [7:0] CHAR_ZERO   = 8'd48;
    localparam logic [7:0] ALPHA_LOWER = 8'd87;
    localparam logic [7:0] ALPHA_UPPER = 8'd55;
    localparam logic [7:0] CHAR_X      = 8'd120;
    localparam logic [7:0] CHAR_LPAREN = 8'd40;
    localparam logic [7:0] CHAR_N      = 8'd110;
    localparam logic [7:0] CHAR_I      = 8'd105;
    localparam logic [7:0] CHAR_L      = 8'd108;
    localparam logic [7:0] CHAR_RPAREN = 8'd41;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [7:0]        chr;
        logic              last;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] tgt_t;
        logic [STEP_W-1:0] tgt_f;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            STEP_IDLE:   w = '{ACT_LOAD, 8'd0, 1'b0, COND_ACCEPT, STEP_IDLE, STEP_IDLE};
            STEP_PTR:    w = '{ACT_NONE, 8'd0, 1'b0, COND_VAL_ZERO, STEP_NIL0, STEP_PFX0};
            STEP_PFX0:   w = '{ACT_EMIT_CONST, CHAR_ZERO, 1'b0, COND_ALWAYS,
                               STEP_PFXX, STEP_PFXX};
            STEP_PFXX:   w = '{ACT_EMIT_CONST, CHAR_X, 1'b0, COND_ALWAYS,
                               STEP_SKIP, STEP_SKIP};
            STEP_SKIP:   w = '{ACT_SKIP, 8'd0, 1'b0, COND_SKIP_DONE, STEP_DIGIT, STEP_SKIP};
            STEP_DIGIT:  w = '{ACT_EMIT_DIGIT, 8'd0, 1'b0, COND_LAST_DIGIT,
                               STEP_IDLE, STEP_DIGIT};
            STEP_DABBLE: w = '{ACT_DABBLE, 8'd0, 1'b0, COND_DABBLE_DONE,
                               STEP_SKIP, STEP_DABBLE};
            STEP_NIL0:   w = '{ACT_EMIT_CONST, CHAR_LPAREN, 1'b0, COND_ALWAYS,
                               STEP_NIL1, STEP_NIL1};
            STEP_NIL1:   w = '{ACT_EMIT_CONST, CHAR_N, 1'b0, COND_ALWAYS,
                               STEP_NIL2, STEP_NIL2};
            STEP_NIL2:   w = '{ACT_EMIT_CONST, CHAR_I, 1'b0, COND_ALWAYS,
                               STEP_NIL3, STEP_NIL3};
            STEP_NIL3:   w = '{ACT_EMIT_CONST, CHAR_L, 1'b0, COND_ALWAYS,
                               STEP_NIL4, STEP_NIL4};
            STEP_NIL4:   w = '{ACT_EMIT_CONST, CHAR_RPAREN, 1'b1, COND_ALWAYS,
                               STEP_IDLE, STEP_IDLE};
            default:     w = '{ACT_NONE, 8'd0, 1'b0, COND_ALWAYS, STEP_IDLE, STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [STEP_W-1:0] entry_step(input logic [1:0] op);
        logic [STEP_W-1:0] s;
        case (op)
            OP_PTR:  s = STEP_PTR;
            OP_DEC:  s = STEP_DABBLE;
            default: s = STEP_SKIP;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/integer_to_ascii_formatter.sv
// Sequence: hex skips leading zero digits, then emits the digits; decimal first runs double dabble.
// Pointer adds a zero check and the two prefix characters "0x"; a zero pointer emits "(nil)" instead.
// Throughput: one character per cycle while the output register is drained, one item at a time.
// Item time is set by the microcode sequencer.
// Reset: rst_n asynchronous active low clears the step counter and the output valid.
`default_nettype none

`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // operation [1:0], value [65:2], count_in [96:66], zero pad [103:97]
    input  wire logic [i2a_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // character [7:0], count_out [38:8], zero pad [39]
    output logic [i2a_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tlast
);

    logic [i2a_pkg::STEP_W-1:0]  upc_reg, upc_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [7:0]                  char_reg, char_next;
    logic                        last_reg, last_next;
    logic [i2a_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic [i2a_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [i2a_pkg::VALUE_W-1:0] val_reg, val_next;
    logic [i2a_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [i2a_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        upper_reg, upper_next;

    i2a_pkg::ucode_t             uc;
    logic                        in_accept;
    logic                        out_free;
    logic                        is_emit;
    logic                        cnt_active;
    logic                        stall;
    logic                        cond_true;
    logic                        skip_done;
    logic [1:0]                  in_op;
    logic [i2a_pkg::VALUE_W-1:0] in_value;
    logic [i2a_pkg::COUNT_W-1:0] in_count;
    logic [3:0]                  top_nib;
    logic [7:0]                  digit_char;
    logic [i2a_pkg::COUNT_W-1:0] count_sat;
    logic [i2a_pkg::BCD_W-1:0]   bcd_adj;
    logic [i2a_pkg::BCD_W-1:0]   bcd_shift;

    assign uc        = i2a_pkg::ucode_rom(upc_reg);
    assign in_op     = s_tdata[1:0];
    assign in_value  = s_tdata[65:2];
    assign in_count  = s_tdata[96:66];
    assign s_tready  = (upc_reg == i2a_pkg::STEP_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign is_emit   = (uc.act == i2a_pkg::ACT_EMIT_DIGIT) || (uc.act == i2a_pkg::ACT_EMIT_CONST);
    assign stall     = is_emit && !out_free;
    assign cnt_active = (uc.act == i2a_pkg::ACT_SKIP) || (uc.act == i2a_pkg::ACT_EMIT_DIGIT)
                        || (uc.act == i2a_pkg::ACT_DABBLE);

    assign top_nib   = val_reg[63:60];
    assign skip_done = (top_nib != 4'd0) || (cnt_reg == 6'd1);
    assign count_sat = (count_reg == i2a_pkg::COUNT_MAX) ? count_reg
                                                        : count_reg + 1'b1;

    always_comb
    begin
        if (top_nib < 4'd10)
        begin
            digit_char = i2a_pkg::CHAR_ZERO + {4'd0, top_nib};
        end
        else
        begin
            digit_char = (upper_reg ? i2a_pkg::ALPHA_UPPER : i2a_pkg::ALPHA_LOWER)
                         + {4'd0, top_nib};
        end
    end

    // Add 3 to every BCD digit of 5 or more before the shift.
    always_comb
    begin
        for (int i = 0; i < i2a_pkg::BCD_W / 4; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    assign bcd_shift = {bcd_adj[i2a_pkg::BCD_W-2:0], val_reg[31]};

    always_comb
    begin
        case (uc.cond)
            i2a_pkg::COND_ALWAYS:      cond_true = 1'b1;
            i2a_pkg::COND_ACCEPT:      cond_true = in_accept;
            i2a_pkg::COND_VAL_ZERO:    cond_true = (val_reg == '0);
            i2a_pkg::COND_SKIP_DONE:   cond_true = skip_done;
            i2a_pkg::COND_LAST_DIGIT:  cond_true = (cnt_reg == 6'd1);
            i2a_pkg::COND_DABBLE_DONE: cond_true = (cnt_reg == 6'd1);
            default:                   cond_true = 1'b0;
        endcase
    end

    // Sequencer: hold on a blocked emit, dispatch on the opcode at accept.
    always_comb
    begin
        if (stall)
        begin
            upc_next = upc_reg;
        end
        else if (uc.act == i2a_pkg::ACT_LOAD)
        begin
            upc_next = in_accept ? i2a_pkg::entry_step(in_op) : i2a_pkg::STEP_IDLE;
        end
        else
        begin
            upc_next = cond_true ? uc.tgt_t : uc.tgt_f;
        end
    end

    always_comb
    begin
        val_next       = val_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        upper_next     = upper_reg;
        count_next     = count_reg;
        m_tvalid_next  = m_tvalid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_count_next = out_count_reg;

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (uc.act)
            i2a_pkg::ACT_LOAD:
            begin
                if (in_accept)
                begin
                    count_next = in_count;
                    bcd_next   = '0;
                    upper_next = 1'b0;
                    case (in_op)
                        i2a_pkg::OP_HEX_UPPER:
                        begin
                            val_next   = {in_value[31:0], 32'd0};
                            cnt_next   = i2a_pkg::DIGITS_HEX32;
                            upper_next = 1'b1;
                        end
                        i2a_pkg::OP_DEC:
                        begin
                            val_next = {32'd0, in_value[31:0]};
                            cnt_next = i2a_pkg::DABBLE_BITS;
                        end
                        default:
                        begin
                            val_next = in_value;
                            cnt_next = i2a_pkg::DIGITS_HEX64;
                        end
                    endcase
                end
            end
            i2a_pkg::ACT_DABBLE:
            begin
                bcd_next = bcd_shift;
                if (cnt_reg == 6'd1)
                begin
                    val_next = {bcd_shift, 24'd0};
                    cnt_next = i2a_pkg::DIGITS_DEC;
                end
                else
                begin
                    val_next = {val_reg[62:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            i2a_pkg::ACT_SKIP:
            begin
                if (!skip_done)
                begin
                    val_next = {val_reg[59:0], 4'd0};
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            i2a_pkg::ACT_EMIT_DIGIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    char_next      = digit_char;
                    last_next      = (cnt_reg == 6'd1);
                    out_count_next = count_sat;
                    count_next     = count_sat;
                    val_next       = {val_reg[59:0], 4'd0};
                    cnt_next       = cnt_reg - 1'b1;
                end
            end
            i2a_pkg::ACT_EMIT_CONST:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    char_next      = uc.chr;
                    last_next      = uc.last;
                    out_count_next = count_sat;
                    count_next     = count_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg      <= i2a_pkg::STEP_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            upc_reg      <= upc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        bcd_reg       <= bcd_next;
        cnt_reg       <= cnt_next;
        upper_reg     <= upper_next;
        count_reg     <= count_next;
        char_reg      <= char_next;
        last_reg      <= last_next;
        out_count_reg <= out_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {1'b0, out_count_reg, char_reg};

    `I2A_ASSERT_NEXT(a_emit_hold, clk, rst_n, stall, $stable(upc_reg))
    `I2A_ASSERT(a_cnt_nonzero, clk, rst_n, !(cnt_active && cnt_reg == 6'd0))
    `I2A_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_accept, upc_reg != i2a_pkg::STEP_IDLE)
    `I2A_ASSERT_NEXT(a_emit_loads, clk, rst_n, is_emit && out_free, m_tvalid_reg)

endmodule

`default_nettype wire
